// ===== hdl/multilevel_priority_queue_assert.svh =====
// Assertion macros for the multilevel priority queue.
// Used by multilevel_priority_queue.sv; needs clk and rst_n in scope.
`ifndef MULTILEVEL_PRIORITY_QUEUE_ASSERT_SVH
`define MULTILEVEL_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MLPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MLPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mlpq_pkg.sv =====
// Shared types and constants for the multilevel priority queue.
// No dependencies; used by mlpq_ram.sv and multilevel_priority_queue.sv.
package mlpq_pkg;

  localparam int LEVELS_DEF     = 8;
  localparam int DEPTH_DEF      = 8;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int ADDR_W_DEF     = 6;

  localparam int CFG_W    = 4;
  localparam int PRIO_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int LEVEL_W  = 3;

  localparam logic [CFG_W-1:0] CFG_LEVELS_RST = 4'd8;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_PUSHED    = 3'd0,
    STAT_POPPED    = 3'd1,
    STAT_OVERFLOW  = 3'd2,
    STAT_UNDERFLOW = 3'd3,
    STAT_BADPRIO   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOOKUP = 2'd1,
    ST_FETCH  = 2'd2,
    ST_DONE   = 2'd3
  } state_t;

endpackage

// ===== hdl/mlpq_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on mlpq_pkg for default sizes.
module mlpq_ram #(
  parameter int WIDTH  = mlpq_pkg::DATA_WIDTH_DEF,
  parameter int ADDR_W = mlpq_pkg::ADDR_W_DEF
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/multilevel_priority_queue.sv =====
// Multilevel priority queue: one circular FIFO per priority level, level 0 most urgent.
// A push (action 0) appends value to its level's ring, reporting overflow when the
// ring holds DEPTH entries or a bad priority when priority_req is not below the
// effective levels_in_use (0 acts as 1, above LEVELS acts as LEVELS). A pop
// (action 1) removes the head of the lowest-numbered non-empty level in use and
// returns value and level, or reports underflow. Each transaction gives one result.
// Items are handled one at a time: an item passes the registered read of the per-level
// pointer memory followed, on a successful pop, by the registered read of the entry
// memory; the next item is accepted once its result has moved to the output register.
// A finished result waits in the output register without
// blocking the next item. The configuration port is always ready. Depends on
// mlpq_pkg, mlpq_ram and multilevel_priority_queue_assert.svh.
`include "multilevel_priority_queue_assert.svh"

module multilevel_priority_queue #(
  parameter int LEVELS     = mlpq_pkg::LEVELS_DEF,
  parameter int DEPTH      = mlpq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = mlpq_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mlpq_pkg::CFG_W-1:0]          cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic [mlpq_pkg::PRIO_W-1:0]         in_priority_req,
  input  logic signed [mlpq_pkg::VALUE_W-1:0] in_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mlpq_pkg::STATUS_W-1:0]       out_status,
  output logic signed [mlpq_pkg::VALUE_W-1:0] out_popped_value,
  output logic [mlpq_pkg::LEVEL_W-1:0]        out_popped_level
);

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int N_W    = $clog2(LEVELS + 1);
  localparam int CMP_W  = (N_W > mlpq_pkg::CFG_W) ? N_W : mlpq_pkg::CFG_W;
  localparam int META_W = 2 * PTR_W + CNT_W;
  localparam int ENT_AW = LVL_W + PTR_W;

  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [CNT_W-1:0] count;
  } meta_t;

  mlpq_pkg::state_t state_r, state_nxt;

  logic [mlpq_pkg::CFG_W-1:0] cfg_levels_r;
  logic [LEVELS-1:0]          nonempty_r;
  logic [LEVELS-1:0]          meta_vld_r;
  logic                       meta_hit_r;

  logic                       act_r;
  logic [LVL_W-1:0]           lvl_r;
  logic [DATA_WIDTH-1:0]      val_r;
  logic                       bad_r;
  logic                       none_r;

  logic [mlpq_pkg::STATUS_W-1:0] res_status_r;
  logic [mlpq_pkg::VALUE_W-1:0]  res_value_r;
  logic [mlpq_pkg::LEVEL_W-1:0]  res_level_r;

  logic                          out_valid_r;
  logic [mlpq_pkg::STATUS_W-1:0] out_status_r;
  logic [mlpq_pkg::VALUE_W-1:0]  out_value_r;
  logic [mlpq_pkg::LEVEL_W-1:0]  out_level_r;

  logic              in_fire;
  logic              out_free;
  logic [CMP_W-1:0]  cfg_ext;
  logic [CMP_W-1:0]  n_eff;
  logic [CMP_W-1:0]  prio_ext;
  logic [CMP_W-1:0]  lvl_ext;
  logic [LVL_W-1:0]  sel_lvl;
  logic              sel_found;
  logic [LVL_W-1:0]  lvl_nxt;

  logic [META_W-1:0] meta_rdata;
  meta_t             meta_cur;
  meta_t             meta_new;
  logic [PTR_W-1:0]  head_inc;
  logic [PTR_W-1:0]  tail_inc;
  logic              full;

  logic              meta_we;
  logic              ent_we;
  logic              ent_re;
  logic              load_lookup;
  logic              load_fetch;
  logic              load_out;
  logic [mlpq_pkg::STATUS_W-1:0] lookup_status;

  logic [ENT_AW-1:0]     ent_waddr;
  logic [ENT_AW-1:0]     ent_raddr;
  logic [DATA_WIDTH-1:0] ent_rdata;
  logic signed [63:0]    in_value_sx;
  logic signed [63:0]    ent_rdata_sx;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != mlpq_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // effective level count, clamped to 1..LEVELS
  assign cfg_ext = CMP_W'(cfg_levels_r);
  always_comb begin
    if (cfg_ext == '0) begin
      n_eff = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(LEVELS)) begin
      n_eff = CMP_W'(LEVELS);
    end else begin
      n_eff = cfg_ext;
    end
  end

  assign prio_ext = CMP_W'(in_priority_req);

  // fixed priority encoder over non-empty levels in use
  always_comb begin
    sel_found = 1'b0;
    sel_lvl   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_r[i] && (CMP_W'(i) < n_eff)) begin
        sel_found = 1'b1;
        sel_lvl   = LVL_W'(i);
      end
    end
  end

  assign lvl_nxt = (in_action == mlpq_pkg::ACT_POP) ? sel_lvl : prio_ext[LVL_W-1:0];

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_action;
      lvl_r  <= lvl_nxt;
      val_r  <= in_value_sx[DATA_WIDTH-1:0];
      bad_r  <= (in_action == mlpq_pkg::ACT_PUSH) && (prio_ext >= n_eff);
      none_r <= (in_action == mlpq_pkg::ACT_POP) && !sel_found;
    end
  end

  assign in_value_sx = 64'(in_value);

  // per-level pointer memory; an entry never written is taken as zero via meta_vld_r
  mlpq_ram #(
    .WIDTH  (META_W),
    .ADDR_W (LVL_W)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (lvl_r),
    .wdata (meta_new),
    .re    (in_fire),
    .raddr (lvl_nxt),
    .rdata (meta_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      meta_hit_r <= meta_vld_r[lvl_nxt];
    end
  end

  assign meta_cur = meta_hit_r ? meta_t'(meta_rdata) : meta_t'('0);
  assign full     = (meta_cur.count == CNT_W'(DEPTH));
  assign head_inc = (meta_cur.head == PTR_W'(DEPTH - 1)) ? '0 : meta_cur.head + 1'b1;
  assign tail_inc = (meta_cur.tail == PTR_W'(DEPTH - 1)) ? '0 : meta_cur.tail + 1'b1;

  always_comb begin
    meta_new = meta_cur;
    if (act_r == mlpq_pkg::ACT_PUSH) begin
      meta_new.tail  = tail_inc;
      meta_new.count = meta_cur.count + 1'b1;
    end else begin
      meta_new.head  = head_inc;
      meta_new.count = meta_cur.count - 1'b1;
    end
  end

  // entry memory, addressed by level and ring slot
  assign ent_waddr = {lvl_r, meta_cur.tail};
  assign ent_raddr = {lvl_r, meta_cur.head};

  mlpq_ram #(
    .WIDTH  (DATA_WIDTH),
    .ADDR_W (ENT_AW)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (val_r),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign ent_rdata_sx = 64'(signed'(ent_rdata));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mlpq_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = mlpq_pkg::ST_LOOKUP;
        end
      end
      mlpq_pkg::ST_LOOKUP: begin
        if (act_r == mlpq_pkg::ACT_POP && !none_r) begin
          state_nxt = mlpq_pkg::ST_FETCH;
        end else begin
          state_nxt = mlpq_pkg::ST_DONE;
        end
      end
      mlpq_pkg::ST_FETCH: begin
        state_nxt = mlpq_pkg::ST_DONE;
      end
      mlpq_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = mlpq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mlpq_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    meta_we       = 1'b0;
    ent_we        = 1'b0;
    ent_re        = 1'b0;
    load_lookup   = 1'b0;
    load_fetch    = 1'b0;
    load_out      = 1'b0;
    lookup_status = mlpq_pkg::STAT_PUSHED;
    case (state_r)
      mlpq_pkg::ST_LOOKUP: begin
        load_lookup = 1'b1;
        if (act_r == mlpq_pkg::ACT_PUSH) begin
          if (bad_r) begin
            lookup_status = mlpq_pkg::STAT_BADPRIO;
          end else if (full) begin
            lookup_status = mlpq_pkg::STAT_OVERFLOW;
          end else begin
            lookup_status = mlpq_pkg::STAT_PUSHED;
            meta_we       = 1'b1;
            ent_we        = 1'b1;
          end
        end else begin
          if (none_r) begin
            lookup_status = mlpq_pkg::STAT_UNDERFLOW;
          end else begin
            lookup_status = mlpq_pkg::STAT_POPPED;
            meta_we       = 1'b1;
            ent_re        = 1'b1;
          end
        end
      end
      mlpq_pkg::ST_FETCH: begin
        load_fetch = 1'b1;
      end
      mlpq_pkg::ST_DONE: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  // pending result
  assign lvl_ext = CMP_W'(lvl_r);

  always_ff @(posedge clk) begin
    if (load_lookup) begin
      res_status_r <= lookup_status;
      res_value_r  <= '0;
      res_level_r  <= '0;
    end else if (load_fetch) begin
      res_status_r <= mlpq_pkg::STAT_POPPED;
      res_value_r  <= ent_rdata_sx[mlpq_pkg::VALUE_W-1:0];
      res_level_r  <= lvl_ext[mlpq_pkg::LEVEL_W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mlpq_pkg::ST_IDLE;
      cfg_levels_r <= mlpq_pkg::CFG_LEVELS_RST;
      nonempty_r   <= '0;
      meta_vld_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_levels_r <= cfg_data;
      end
      if (meta_we) begin
        meta_vld_r[lvl_r] <= 1'b1;
        nonempty_r[lvl_r] <= (meta_new.count != '0);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_level_r  <= res_level_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_value_r;
  assign out_popped_level = out_level_r;

  `MLPQ_ASSERT_NOW(a_flag_matches_count, state_r == mlpq_pkg::ST_LOOKUP, (meta_cur.count != '0) == nonempty_r[lvl_r], "non-empty flag disagrees with level count")
  `MLPQ_ASSERT_NOW(a_count_bounded, state_r == mlpq_pkg::ST_LOOKUP, meta_cur.count <= CNT_W'(DEPTH), "level count above ring depth")
  `MLPQ_ASSERT_NOW(a_entry_write_push, ent_we, act_r == mlpq_pkg::ACT_PUSH && !bad_r && !ent_re, "entry write outside a valid push")
  `MLPQ_ASSERT_NEXT(a_pop_fetches, ent_re, state_r == mlpq_pkg::ST_FETCH && act_r == mlpq_pkg::ACT_POP, "entry read not followed by fetch")

endmodule
